// ----- design/ifp_pkg.sv -----
// ----------------------------------------------------------------------------
// ifp_pkg
// Shared types, constants and the byte-wide CRC-16 step for the IMU frame
// parser.
// ----------------------------------------------------------------------------
package ifp_pkg;

  // Frame header and CRC constants
  localparam logic [7:0]  HdrFirst  = 8'h5A;
  localparam logic [7:0]  HdrSecond = 8'hA5;
  localparam logic [15:0] CrcPoly   = 16'h1021;

  // Frame position codes
  localparam logic [5:0] PosHunt     = 6'd0;
  localparam logic [5:0] PosHdr2     = 6'd1;
  localparam logic [5:0] PosLen0     = 6'd2;
  localparam logic [5:0] PosLen1     = 6'd3;
  localparam logic [5:0] PosCrcLo    = 6'd4;
  localparam logic [5:0] PosCrcHi    = 6'd5;
  localparam logic [5:0] PosPayFirst = 6'd6;
  localparam logic [5:0] PosLast     = 6'd33;

  // Payload layout: 4 groups of tag + 3 little-endian 16-bit samples
  localparam int NumGroups  = 4;
  localparam int GroupBytes = 7;
  localparam int NumSlots   = 24;  // sample bytes kept, tags dropped

  localparam logic [1:0] GrpAccel = 2'd0;
  localparam logic [1:0] GrpAngle = 2'd3;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } sample_t;

  // Completed frame handed from parser to emitter
  typedef struct packed {
    logic                          valid;
    logic                          crc_err;
    sample_t [NumGroups-1:0]       grp;
  } frame_t;

  typedef struct packed {
    logic       en;
    logic [4:0] idx;
  } slot_t;

  // One CRC-16 step over a full byte, MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                             input logic [7:0]  b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // Map a payload offset (0..27) to a sample-byte slot; tag bytes map to none
  function automatic slot_t pay_slot(input logic [4:0] off);
    slot_t s;
    s.en  = 1'b0;
    s.idx = '0;
    for (int g = 0; g < NumGroups; g++) begin
      if (off > 5'(GroupBytes * g) && off <= 5'(GroupBytes * g + 6)) begin
        s.en  = 1'b1;
        s.idx = 5'(off - 5'(g + 1));
      end
    end
    return s;
  endfunction

endpackage

// ----- design/ifp_rx_if.sv -----
// ----------------------------------------------------------------------------
// ifp_rx_if
// Byte channel from the serial receiver: valid/ready plus one data word.
// ----------------------------------------------------------------------------
interface ifp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- design/ifp_res_if.sv -----
// ----------------------------------------------------------------------------
// ifp_res_if
// Result channel: one sensor group sample triple per word.
// ----------------------------------------------------------------------------
interface ifp_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         group;
  logic signed [15:0] value_x;
  logic signed [15:0] value_y;
  logic signed [15:0] value_z;
  logic               status;
  logic               last;

  modport source (output valid, output group, output value_x, output value_y,
                  output value_z, output status, output last, input ready);
  modport sink   (input valid, input group, input value_x, input value_y,
                  input value_z, input status, input last, output ready);
endinterface

// ----- design/ifp_parser.sv -----
// ----------------------------------------------------------------------------
// ifp_parser
// Header hunt, position tracking, byte-wide CRC and sample byte store.
// Flags a completed frame in the cycle its last payload byte is taken.
// ----------------------------------------------------------------------------
module ifp_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            take_i,
  input  logic [7:0]      byte_i,
  output logic [5:0]      pos_o,
  output ifp_pkg::frame_t frame_o
);
  import ifp_pkg::*;

  logic [5:0]  pos_q, pos_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] crc_rx_q, crc_rx_d;
  logic [7:0]  pay_q [NumSlots];
  logic [7:0]  pay_full [NumSlots];
  logic [15:0] crc_step;
  logic [4:0]  pay_off;
  slot_t       slot;
  logic        is_pay;
  logic        done;

  assign crc_step = crc16_byte(crc_q, byte_i);
  assign pay_off  = 5'(pos_q - PosPayFirst);
  assign slot     = pay_slot(pay_off);
  assign is_pay   = (pos_q >= PosPayFirst) && (pos_q <= PosLast);

  // Next-state per accepted byte
  always_comb begin
    pos_d    = pos_q;
    crc_d    = crc_q;
    crc_rx_d = crc_rx_q;
    done     = 1'b0;
    if (take_i) begin
      case (pos_q)
        PosHdr2: begin
          if (byte_i == HdrSecond) begin
            crc_d = crc_step;
            pos_d = PosLen0;
          end else begin
            pos_d = PosHunt;
          end
        end
        PosLen0, PosLen1: begin
          crc_d = crc_step;
          pos_d = pos_q + 6'd1;
        end
        PosCrcLo: begin
          crc_rx_d = {8'h00, byte_i};
          pos_d    = PosCrcHi;
        end
        PosCrcHi: begin
          crc_rx_d = {byte_i, crc_rx_q[7:0]};
          pos_d    = PosPayFirst;
        end
        default: begin
          if (is_pay) begin
            crc_d = crc_step;
            if (pos_q == PosLast) begin
              pos_d = PosHunt;
              done  = 1'b1;
            end else begin
              pos_d = pos_q + 6'd1;
            end
          end else if (byte_i == HdrFirst) begin
            // hunting (also any out-of-range position)
            crc_d = crc16_byte(16'h0000, byte_i);
            pos_d = PosHdr2;
          end else begin
            pos_d = PosHunt;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= PosHunt;
      crc_q    <= '0;
      crc_rx_q <= '0;
    end else begin
      pos_q    <= pos_d;
      crc_q    <= crc_d;
      crc_rx_q <= crc_rx_d;
    end
  end

  // Sample byte store, tags skipped
  always_ff @(posedge clk_i) begin
    if (take_i && is_pay && slot.en) begin
      pay_q[slot.idx] <= byte_i;
    end
  end

  // Final byte bypasses the store
  always_comb begin
    for (int s = 0; s < NumSlots; s++) begin
      pay_full[s] = pay_q[s];
    end
    pay_full[NumSlots-1] = byte_i;
  end

  // Completed frame
  always_comb begin
    frame_o.valid   = done;
    frame_o.crc_err = (crc_step != crc_rx_q);
    for (int g = 0; g < NumGroups; g++) begin
      frame_o.grp[g].x = {pay_full[6*g+1], pay_full[6*g]};
      frame_o.grp[g].y = {pay_full[6*g+3], pay_full[6*g+2]};
      frame_o.grp[g].z = {pay_full[6*g+5], pay_full[6*g+4]};
    end
  end

  assign pos_o = pos_q;

  // Checks
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosLast)
    else $error("frame position out of range");

  a_done_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> pos_q == PosHunt)
    else $error("parser did not return to hunt after frame end");

endmodule

// ----- design/ifp_emitter.sv -----
// ----------------------------------------------------------------------------
// ifp_emitter
// Result register: holds one completed frame and hands out its group words
// (four on a good frame, one error word on a CRC mismatch).
// ----------------------------------------------------------------------------
module ifp_emitter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ifp_pkg::frame_t frame_i,
  output logic            busy_o,
  ifp_res_if.source       res_o
);
  import ifp_pkg::*;

  logic            busy_q, busy_d;
  logic            err_q;
  logic [1:0]      idx_q, idx_d;
  sample_t         grp_q [NumGroups];
  sample_t         cur;
  logic            is_last;
  logic            fire;

  assign cur     = grp_q[idx_q];
  assign is_last = err_q || (idx_q == GrpAngle);
  assign fire    = res_o.valid && res_o.ready;

  // Word sequencing
  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (frame_i.valid) begin
      busy_d = 1'b1;
      idx_d  = GrpAccel;
    end else if (fire) begin
      if (is_last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= GrpAccel;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  // Frame payload
  always_ff @(posedge clk_i) begin
    if (frame_i.valid) begin
      err_q <= frame_i.crc_err;
      for (int g = 0; g < NumGroups; g++) begin
        grp_q[g] <= frame_i.grp[g];
      end
    end
  end

  // Output word
  assign res_o.valid   = busy_q;
  assign res_o.group   = err_q ? GrpAccel : idx_q;
  assign res_o.value_x = err_q ? 16'sd0 : cur.x;
  assign res_o.value_y = err_q ? 16'sd0 : cur.y;
  assign res_o.value_z = err_q ? 16'sd0 : cur.z;
  assign res_o.status  = err_q;
  assign res_o.last    = is_last;
  assign busy_o        = busy_q;

  // Checks
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_i.valid |-> !busy_q)
    else $error("new frame loaded over pending words");

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && err_q) |-> idx_q == GrpAccel)
    else $error("error frame stepped past its single word");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && is_last && !frame_i.valid) |=> !busy_q)
    else $error("emitter still busy after final word");

  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !is_last) |=> busy_q && idx_q == $past(idx_q) + 2'd1)
    else $error("group index did not advance");

endmodule

// ----- design/imu_frame_parser_crc16.sv -----
// ----------------------------------------------------------------------------
// imu_frame_parser_crc16
// Timing: a frame's first result word is valid in the cycle after its last
//   payload byte is accepted; later words come one per cycle while ready is high.
// Throughput: one byte per cycle; the byte ending a frame is held off only
//   while the previous frame's words are still pending in the result register.
// Reset: asynchronous, active low; returns to header hunt with CRC state zero.
// ----------------------------------------------------------------------------
module imu_frame_parser_crc16 (
  input  logic      clk_i,
  input  logic      rst_ni,
  ifp_rx_if.sink    rx_i,
  ifp_res_if.source res_o
);
  import ifp_pkg::*;

  logic       take;
  logic       busy;
  logic [5:0] pos;
  frame_t     frame;

  // Hold off the closing byte while the result register is occupied
  assign rx_i.ready = (pos != PosLast) || !busy;
  assign take       = rx_i.valid && rx_i.ready;

  ifp_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .byte_i  (rx_i.rx_byte),
    .pos_o   (pos),
    .frame_o (frame)
  );

  ifp_emitter u_emitter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .frame_i (frame),
    .busy_o  (busy),
    .res_o   (res_o)
  );

endmodule
